[rtl/assert_macros.svh]
// Assertion macros shared by the ring log offset manager RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/frlo_pkg.sv]
// Package for the ring log offset manager: widths, codes, types, helpers.
// No dependencies; imported by every module of the block.
`default_nettype none

package frlo_pkg;

   // record size must be a power of two
   localparam int unsigned RECORD_BYTES = 32;
   localparam int unsigned REC_LOG2     = $clog2(RECORD_BYTES);

   localparam int unsigned POS_W      = 32;
   localparam int unsigned UNIT_W     = 25;
   localparam int unsigned BACK_W     = 27;
   localparam int unsigned STORE_W    = 28;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned WIDE_W     = POS_W + 1;
   localparam int unsigned NEED_W     = STORE_W + REC_LOG2;
   localparam int unsigned CMP_W      = (NEED_W > WIDE_W) ? NEED_W : WIDE_W;
   localparam int unsigned DIV_CNT_W  = $clog2(POS_W);

   localparam logic [POS_W-1:0]   REC_MASK     = ~(POS_W'(RECORD_BYTES - 1));
   localparam logic [WIDE_W-1:0]  REC_WIDE     = WIDE_W'(RECORD_BYTES);
   localparam logic [POS_W-1:0]   REGION_RESET = POS_W'(1048576);
   localparam logic [UNIT_W-1:0]  UNIT_RESET   = UNIT_W'(4096);
   localparam logic [STORE_W-1:0] STORE_MAX    = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT   = 2'd1;

   localparam logic CMD_ALLOC  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_PREP = 8'b0000_0010,
      S_DIV  = 8'b0000_0100,
      S_SKIP = 8'b0000_1000,
      S_FIT  = 8'b0001_0000,
      S_OUT  = 8'b0010_0000,
      S_LK1  = 8'b0100_0000,
      S_LK2  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic              start;
      logic [POS_W-1:0]  dividend;
      logic [UNIT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [UNIT_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [STORE_W-1:0] stored_sat(input logic [POS_W-1:0] bytes);
      logic [POS_W-1:0] recs;
      recs = bytes >> REC_LOG2;
      if (recs > POS_W'(STORE_MAX)) begin
         return STORE_MAX;
      end
      return recs[STORE_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/frlo_rem_unit.sv]
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on frlo_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module frlo_rem_unit
   import frlo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [POS_W-1:0]     dvd_ff, dvd_in;
   logic [UNIT_W:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [UNIT_W:0]      trial;
   logic [UNIT_W:0]      div_ext;
   logic                 last;

   assign trial   = {rem_ff[UNIT_W-1:0], dvd_ff[POS_W-1]};
   assign div_ext = {1'b0, div_req.divisor};
   assign last    = (cnt_ff == DIV_CNT_W'(POS_W - 1));

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = (trial >= div_ext) ? (trial - div_ext) : trial;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (last) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff[UNIT_W-1:0];

   `ASSERT_IMPL(a_start_when_free, clock, reset, div_req.start, !run_ff)
   `ASSERT_NEXT(a_done_after_last, clock, reset, run_ff && last && !div_req.start, done_ff)
   `ASSERT_IMPL(a_rem_below_div, clock, reset, done_ff && (div_req.divisor != '0), rem_ff < div_ext)

endmodule

`default_nettype wire

[rtl/flash_ring_log_offset_manager_unit.sv]
// Top level of the ring log offset manager: command sequencer and state.
// Depends on frlo_pkg, frlo_rem_unit and assert_macros.svh.
//
//  channel  | ports                                  | handshake
//  request  | start, busy, req_command, req_back_index | start & !busy
//  response | rsp_valid, rsp_*                       | one-cycle strobe
//  config   | csr_valid, csr_ready, csr_index, csr_wdata | valid & ready
//
// Allocate passes through prep, the bit-serial sector remainder (32 steps), the
// skip check, a fit step when the record skips to the next sector, and output.
// Allocate with erase unit zero goes from prep straight to output. Lookup: prep, then two lookup states.
// One command at a time; busy is high from accept until the result strobe.
// Reset is synchronous; the result is registered and cannot be stalled.
`default_nettype none
`include "assert_macros.svh"

module flash_ring_log_offset_manager_unit
   import frlo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [BACK_W-1:0]     req_back_index,
   output logic                  rsp_valid,
   output logic [POS_W-1:0]      rsp_byte_offset,
   output logic                  rsp_ok,
   output logic                  rsp_erase_first,
   output logic [STORE_W-1:0]    rsp_stored_count,
   output logic                  rsp_has_wrapped,
   output logic [CNT_W-1:0]      rsp_total_written,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [BACK_W-1:0]   back_ff, back_in;
   logic [POS_W-1:0]    region_ff, region_in;
   logic [UNIT_W-1:0]   unit_ff, unit_in;
   logic [POS_W-1:0]    usable_ff, usable_in;
   logic [POS_W-1:0]    wp_ff, wp_in;
   logic                wrap_ff, wrap_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [POS_W-1:0]    off_ff, off_in;
   logic [WIDE_W-1:0]   end_ff, end_in;
   logic                erase_ff, erase_in;
   logic                hit_ff, hit_in;
   logic [CMP_W-1:0]    need_ff, need_in;
   logic [CMP_W-1:0]    sum_ff, sum_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_off_ff, rsp_off_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic                rsp_erase_ff, rsp_erase_in;
   logic [STORE_W-1:0]  rsp_stored_ff, rsp_stored_in;
   logic                rsp_wrap_ff, rsp_wrap_in;
   logic [CNT_W-1:0]    rsp_total_ff, rsp_total_in;

   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                wp_over;
   logic [POS_W-1:0]    wp_wrapped;
   logic [WIDE_W-1:0]   unit_end;
   logic                skip_hit;
   logic                end_over;
   logic [WIDE_W-1:0]   adv;
   logic [POS_W-1:0]    wp_next;
   logic [POS_W-1:0]    held;
   logic [NEED_W-1:0]   need_c;
   logic                lk_back;
   logic [CMP_W-1:0]    wp_cmp;
   logic [CMP_W-1:0]    lk_off;

   assign wp_over    = (wp_ff >= usable_ff);
   assign wp_wrapped = wp_over ? '0 : wp_ff;
   assign unit_end   = WIDE_W'(off_ff) - WIDE_W'(div_rsp.remainder) + WIDE_W'(unit_ff);
   assign skip_hit   = (WIDE_W'(off_ff) + REC_WIDE) > end_ff;
   assign end_over   = (end_ff + REC_WIDE) > WIDE_W'(usable_ff);
   assign adv        = WIDE_W'(off_ff) + REC_WIDE;
   assign wp_next    = adv[POS_W] ? '1 : adv[POS_W-1:0];
   assign held       = (wrap_ff ? usable_ff : wp_ff) >> REC_LOG2;
   assign need_c     = (NEED_W'(back_ff) + NEED_W'(1)) << REC_LOG2;
   assign wp_cmp     = CMP_W'(wp_ff);
   assign lk_back    = (need_ff <= wp_cmp);
   assign lk_off     = lk_back ? (wp_cmp - need_ff) : (sum_ff - need_ff);

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      back_in       = back_ff;
      region_in     = region_ff;
      unit_in       = unit_ff;
      usable_in     = usable_ff;
      wp_in         = wp_ff;
      wrap_in       = wrap_ff;
      cnt_in        = cnt_ff;
      off_in        = off_ff;
      end_in        = end_ff;
      erase_in      = erase_ff;
      hit_in        = hit_ff;
      need_in       = need_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = 1'b0;
      rsp_off_in    = rsp_off_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_erase_in  = rsp_erase_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_wrap_in   = rsp_wrap_ff;
      rsp_total_in  = rsp_total_ff;
      div_req.start    = 1'b0;
      div_req.dividend = wp_wrapped;
      div_req.divisor  = unit_ff;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_REGION: begin
                     region_in = csr_wdata;
                     usable_in = csr_wdata & REC_MASK;
                     wp_in     = '0;
                     wrap_in   = 1'b0;
                     cnt_in    = '0;
                  end
                  CSR_UNIT: begin
                     unit_in   = csr_wdata[UNIT_W-1:0];
                     usable_in = region_ff & REC_MASK;
                     wp_in     = '0;
                     wrap_in   = 1'b0;
                     cnt_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
            if (start) begin
               cmd_in   = req_command;
               back_in  = req_back_index;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (cmd_ff == CMD_LOOKUP) begin
               state_in = S_LK1;
            end else begin
               wrap_in  = wrap_ff | wp_over;
               off_in   = wp_wrapped;
               erase_in = 1'b0;
               if (unit_ff == '0) begin
                  state_in = S_OUT;
               end else begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               end_in   = unit_end;
               erase_in = (div_rsp.remainder == '0);
               state_in = S_SKIP;
            end
         end
         S_SKIP: begin
            state_in = skip_hit ? S_FIT : S_OUT;
         end
         S_FIT: begin
            erase_in = 1'b1;
            if (end_over) begin
               off_in  = '0;
               wrap_in = 1'b1;
            end else begin
               off_in = end_ff[POS_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            wp_in         = wp_next;
            cnt_in        = cnt_ff + CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_off_in    = off_ff;
            rsp_ok_in     = 1'b1;
            rsp_erase_in  = erase_ff;
            rsp_stored_in = stored_sat(wrap_ff ? usable_ff : wp_next);
            rsp_wrap_in   = wrap_ff;
            rsp_total_in  = cnt_ff + CNT_W'(1);
            state_in      = S_IDLE;
         end
         S_LK1: begin
            hit_in   = (POS_W'(back_ff) < held);
            need_in  = CMP_W'(need_c);
            sum_in   = CMP_W'(wp_ff) + CMP_W'(usable_ff);
            state_in = S_LK2;
         end
         S_LK2: begin
            rsp_valid_in  = 1'b1;
            rsp_ok_in     = hit_ff && (lk_back || wrap_ff);
            rsp_off_in    = (hit_ff && (lk_back || wrap_ff)) ? lk_off[POS_W-1:0] : '0;
            rsp_erase_in  = 1'b0;
            rsp_stored_in = stored_sat(wrap_ff ? usable_ff : wp_ff);
            rsp_wrap_in   = wrap_ff;
            rsp_total_in  = cnt_ff;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         region_ff    <= REGION_RESET;
         unit_ff      <= UNIT_RESET;
         usable_ff    <= REGION_RESET & REC_MASK;
         wp_ff        <= '0;
         wrap_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         region_ff    <= region_in;
         unit_ff      <= unit_in;
         usable_ff    <= usable_in;
         wp_ff        <= wp_in;
         wrap_ff      <= wrap_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      back_ff       <= back_in;
      off_ff        <= off_in;
      end_ff        <= end_in;
      erase_ff      <= erase_in;
      hit_ff        <= hit_in;
      need_ff       <= need_in;
      sum_ff        <= sum_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_erase_ff  <= rsp_erase_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_wrap_ff   <= rsp_wrap_in;
      rsp_total_ff  <= rsp_total_in;
   end

   frlo_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_offset   = rsp_off_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_erase_first   = rsp_erase_ff;
   assign rsp_stored_count  = rsp_stored_ff;
   assign rsp_has_wrapped   = rsp_wrap_ff;
   assign rsp_total_written = rsp_total_ff;

   `ASSERT_NEXT(a_rsp_from_final, clock, reset, state_ff == S_OUT || state_ff == S_LK2, rsp_valid_ff)
   `ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid_ff && !rsp_ok_ff, rsp_byte_offset == '0)
   `ASSERT_IMPL(a_erase_alloc, clock, reset, rsp_valid_ff && rsp_erase_ff, rsp_ok_ff)
   `ASSERT_IMPL(a_div_only_alloc, clock, reset, state_ff == S_DIV, cmd_ff == CMD_ALLOC && unit_ff != '0)

endmodule

`default_nettype wire
